/* sv/register_write_shadow_store_unit_defines.svh */
// Assertion macros for the register write shadow store unit.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef REGISTER_WRITE_SHADOW_STORE_UNIT_DEFINES_SVH
`define REGISTER_WRITE_SHADOW_STORE_UNIT_DEFINES_SVH

// same-cycle implication
`define RWSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rwss_pkg.sv */
// Shared constants and types of the register write shadow store unit.
// No dependencies.
package rwss_pkg;

  localparam int unsigned SHADOW_ENTRIES = 256;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned WCODE_W        = 3;
  localparam int unsigned DATA_W         = 64;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // request held for the whole walk down the chain
  typedef struct packed {
    logic               is_write;
    logic [ADDR_W-1:0]  addr;
    logic [WCODE_W-1:0] wcode;
    logic [DATA_W-1:0]  data;
  } key_t;

  // beat handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] rdata;
  } token_t;

endpackage

/* sv/rwss_cell.sv */
// One shadow entry: compares the passing request and hands the token on.
// Depends on rwss_pkg.
module rwss_cell
  import rwss_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  key_t   key_i,
  input  token_t tok_i,
  output token_t tok_o
);

  logic               valid_q, valid_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [WCODE_W-1:0] wcode_q, wcode_d;
  logic [DATA_W-1:0]  value_q, value_d;
  token_t             tok_q, tok_d;
  logic               act;
  logic               match;

  assign act   = tok_i.vld && !tok_i.done;
  assign match = valid_q && (addr_q == key_i.addr) && (wcode_q == key_i.wcode);

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    addr_d  = addr_q;
    wcode_d = wcode_q;
    value_d = value_q;
    if (act) begin
      if (match) begin
        tok_d.done = 1'b1;
        if (key_i.is_write == REQ_WRITE) begin
          value_d = key_i.data;
        end else begin
          tok_d.hit   = 1'b1;
          tok_d.rdata = value_q;
        end
      end else if (!valid_q) begin
        // valid entries form a prefix: first free entry ends the search
        tok_d.done = 1'b1;
        if (key_i.is_write == REQ_WRITE) begin
          valid_d = 1'b1;
          addr_d  = key_i.addr;
          wcode_d = key_i.wcode;
          value_d = key_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    wcode_q <= wcode_d;
    value_q <= value_d;
  end

  assign tok_o = tok_q;

endmodule

/* sv/register_write_shadow_store_unit.sv */
// Top level of the register write shadow store unit: request register,
// chain of rwss_cell entries and result register. Depends on rwss_pkg.
//
//  channel   handshake            payload
//  request   start_i / busy_o     req_type_i, access_address_i, access_width_i, write_data_i
//  result    done_o (strobe)      read_data_o, shadow_hit_o, pass_through_o, write_dropped_o
//
// One request at a time; a token walks the chain one entry per cycle.
// Result strobe is registered from the chain tail, behind the launch register and
// every cell's token register; busy_o drops with it, so a new request can be taken while it shows.
// Reset empties the table at once (per-entry valid flops).
// Result beat lasts one cycle; the receiver cannot stall.
module register_write_shadow_store_unit
  import rwss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [ADDR_W-1:0]  access_address_i,
  input  logic [WCODE_W-1:0] access_width_i,
  input  logic [DATA_W-1:0]  write_data_i,
  output logic               done_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               shadow_hit_o,
  output logic               pass_through_o,
  output logic               write_dropped_o
);

  key_t   key_q;
  logic   busy_q;
  logic   launch_q;
  logic   done_q;
  logic   accept;
  token_t tok [SHADOW_ENTRIES+1];
  token_t tail;

  logic [DATA_W-1:0] rdata_q;
  logic              hit_q, pass_q, drop_q;

  assign accept = start_i && !busy_q;
  assign tail   = tok[SHADOW_ENTRIES];

  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = launch_q;
  end

  for (genvar k = 0; k < SHADOW_ENTRIES; k++) begin : g_cell
    rwss_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .key_i (key_q),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q.is_write <= req_type_i;
      key_q.addr     <= access_address_i;
      key_q.wcode    <= access_width_i;
      key_q.data     <= write_data_i;
    end
    if (tail.vld) begin
      rdata_q <= tail.rdata;
      hit_q   <= tail.hit;
      pass_q  <= (key_q.is_write == REQ_READ) && !tail.hit;
      drop_q  <= (key_q.is_write == REQ_WRITE) && !tail.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      launch_q <= accept;
      done_q   <= tail.vld;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.vld) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign read_data_o     = rdata_q;
  assign shadow_hit_o    = hit_q;
  assign pass_through_o  = pass_q;
  assign write_dropped_o = drop_q;

endmodule

/* sv/rwss_checker.sv */
// Port-level checker for register_write_shadow_store_unit, with its bind.
// Depends on rwss_pkg and register_write_shadow_store_unit_defines.svh.
`include "register_write_shadow_store_unit_defines.svh"

module rwss_checker
  import rwss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [DATA_W-1:0]  read_data_o,
  input logic               shadow_hit_o,
  input logic               pass_through_o,
  input logic               write_dropped_o
);

  `RWSS_ASSERT_NOW(a_one_flag, done_o, $countones({shadow_hit_o, pass_through_o, write_dropped_o}) <= 1, "more than one result flag set")
  `RWSS_ASSERT_NOW(a_miss_zero, done_o && !shadow_hit_o, read_data_o == '0, "read data nonzero without hit")
  `RWSS_ASSERT_NEXT(a_busy_after_start, start_i && !busy_o, busy_o, "accepted beat did not raise busy")
  `RWSS_ASSERT_NOW(a_done_from_busy, done_o, !busy_o && $past(busy_o), "result beat without pending request")

endmodule

bind register_write_shadow_store_unit rwss_checker u_rwss_checker (.*);

/* tb/sv/tb_register_write_shadow_store_unit.sv */
// Self-checking bench for register_write_shadow_store_unit: reads and writes to
// a shadowed register table, predicted per access and checked beat by beat.
// Depends on rwss_pkg and the unit's RTL only.
module tb_register_write_shadow_store_unit
  import rwss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 528;
  localparam int unsigned TOTAL_ITEMS  = 550;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = SHADOW_ENTRIES + 16;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              hit;
    logic              pass;
    logic              dropped;
  } access_result_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               start_i          = 1'b0;
  logic               req_type_i       = REQ_READ;
  logic [ADDR_W-1:0]  access_address_i = '0;
  logic [WCODE_W-1:0] access_width_i   = '0;
  logic [DATA_W-1:0]  write_data_i     = '0;
  logic               busy_o;
  logic               done_o;
  logic [DATA_W-1:0]  read_data_o;
  logic               shadow_hit_o;
  logic               pass_through_o;
  logic               write_dropped_o;

  register_write_shadow_store_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .access_address_i (access_address_i),
    .access_width_i   (access_width_i),
    .write_data_i     (write_data_i),
    .done_o           (done_o),
    .read_data_o      (read_data_o),
    .shadow_hit_o     (shadow_hit_o),
    .pass_through_o   (pass_through_o),
    .write_dropped_o  (write_dropped_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow table copy
  logic               shadow_valid [SHADOW_ENTRIES];
  logic [ADDR_W-1:0]  shadow_addr  [SHADOW_ENTRIES];
  logic [WCODE_W-1:0] shadow_wcode [SHADOW_ENTRIES];
  logic [DATA_W-1:0]  shadow_value [SHADOW_ENTRIES];

  key_t           pending_accesses[$];
  access_result_t due_results[$];
  key_t           written_keys[$];
  int unsigned    accepted_count = 0;
  int unsigned    fail_count     = 0;
  int unsigned    cycle_count    = 0;

  function automatic access_result_t predict_access(key_t req);
    access_result_t res;
    int match_slot;
    int free_slot;
    res = '0;
    match_slot = -1;
    free_slot = -1;
    for (int k = SHADOW_ENTRIES - 1; k >= 0; k--) begin
      if (shadow_valid[k] && shadow_addr[k] == req.addr && shadow_wcode[k] == req.wcode)
        match_slot = k;
      if (!shadow_valid[k])
        free_slot = k;
    end
    if (req.is_write == REQ_WRITE) begin
      if (match_slot >= 0) begin
        shadow_value[match_slot] = req.data;
      end else if (free_slot >= 0) begin
        shadow_valid[free_slot] = 1'b1;
        shadow_addr[free_slot]  = req.addr;
        shadow_wcode[free_slot] = req.wcode;
        shadow_value[free_slot] = req.data;
      end else begin
        res.dropped = 1'b1;
      end
    end else if (match_slot >= 0) begin
      res.rdata = shadow_value[match_slot];
      res.hit   = 1'b1;
    end else begin
      res.pass = 1'b1;
    end
    return res;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic queue_access(logic is_write, logic [ADDR_W-1:0] addr,
                              logic [WCODE_W-1:0] wcode, logic [DATA_W-1:0] data);
    key_t req;
    bit   known;
    req.is_write = is_write;
    req.addr     = addr;
    req.wcode    = wcode;
    req.data     = data;
    known        = 1'b0;
    pending_accesses.push_back(req);
    if (is_write == REQ_WRITE) begin
      foreach (written_keys[k])
        if (written_keys[k].addr == addr && written_keys[k].wcode == wcode)
          known = 1'b1;
      if (!known)
        written_keys.push_back(req);
    end
  endtask

  // sender: holds start_i until the beat is taken, idles by phase
  always @(posedge clk_i) begin : sender
    int unsigned idle_pct;
    bit          present;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        due_results.push_back(predict_access(pending_accesses.pop_front()));
        accepted_count++;
      end
      if (!(start_i && busy_o)) begin
        idle_pct = (accepted_count < TOTAL_ITEMS / 3)     ? 9  :
                   (accepted_count < 2 * TOTAL_ITEMS / 3) ? 56 : 0;
        present = pending_accesses.size() != 0 && $urandom_range(99) >= idle_pct;
        start_i <= present;
        if (present) begin
          req_type_i       <= pending_accesses[0].is_write;
          access_address_i <= pending_accesses[0].addr;
          access_width_i   <= pending_accesses[0].wcode;
          write_data_i     <= pending_accesses[0].data;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    access_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        flag_error("result beat with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (read_data_o !== want.rdata)
          flag_error($sformatf("read_data exp %h got %h", want.rdata, read_data_o));
        if (shadow_hit_o !== want.hit)
          flag_error($sformatf("shadow_hit exp %b got %b", want.hit, shadow_hit_o));
        if (pass_through_o !== want.pass)
          flag_error($sformatf("pass_through exp %b got %b", want.pass, pass_through_o));
        if (write_dropped_o !== want.dropped)
          flag_error($sformatf("write_dropped exp %b got %b", want.dropped, write_dropped_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("register_write_shadow_store_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0]  addr_max;
    logic [ADDR_W-1:0]  addr;
    logic [WCODE_W-1:0] wcode;
    logic               is_write;
    bit                 filling;
    int unsigned        roll;
    key_t               pick;

    addr_max = '1;
    for (int k = 0; k < SHADOW_ENTRIES; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_addr[k]  = '0;
      shadow_wcode[k] = '0;
      shadow_value[k] = '0;
    end

    // directed: empty table, extremes, same address other width, updates
    queue_access(REQ_READ,  '0,       3'd0, '1);
    queue_access(REQ_WRITE, '0,       3'd0, '1);
    queue_access(REQ_READ,  '0,       3'd0, '0);
    queue_access(REQ_READ,  '0,       3'd7, '0);
    queue_access(REQ_WRITE, addr_max, 3'd7, '0);
    queue_access(REQ_READ,  addr_max, 3'd7, '1);
    queue_access(REQ_READ,  addr_max, 3'd0, '0);
    queue_access(REQ_WRITE, '0,       3'd0, 64'h0123_4567_89ab_cdef);
    queue_access(REQ_READ,  '0,       3'd0, '0);
    queue_access(REQ_WRITE, '0,       3'd7, 64'hfedc_ba98_7654_3210);
    queue_access(REQ_READ,  '0,       3'd7, 64'h5555_5555_5555_5555);
    queue_access(REQ_READ,  '0,       3'd0, '0);
    queue_access(REQ_WRITE, addr_max, 3'd7, '1);
    queue_access(REQ_READ,  addr_max, 3'd7, '0);
    queue_access(REQ_WRITE, 48'haaaa_aaaa_aaaa, 3'd2, 64'h5555_5555_5555_5555);
    queue_access(REQ_WRITE, 48'h5555_5555_5555, 3'd5, 64'haaaa_aaaa_aaaa_aaaa);
    queue_access(REQ_READ,  48'haaaa_aaaa_aaaa, 3'd2, '0);
    queue_access(REQ_READ,  48'h5555_5555_5555, 3'd5, '0);
    queue_access(REQ_READ,  48'h5555_5555_5555, 3'd2, '0);
    queue_access(REQ_WRITE, addr_max, 3'd0, 64'h8000_0000_0000_0001);
    queue_access(REQ_READ,  addr_max, 3'd0, '0);
    queue_access(REQ_READ,  48'h0000_0000_0001, 3'd1, '0);

    // random: fill the table early, then hammer a full table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      filling  = written_keys.size() < SHADOW_ENTRIES + 8;
      is_write = ($urandom_range(99) < (filling ? 75 : 50)) ? REQ_WRITE : REQ_READ;
      roll     = $urandom_range(99);
      addr     = ADDR_W'({$urandom, $urandom});
      wcode    = WCODE_W'($urandom_range(7));
      if (written_keys.size() != 0) begin
        pick = written_keys[$urandom_range(written_keys.size() - 1)];
        if (is_write == REQ_WRITE) begin
          if (roll >= (filling ? 90 : 30)) begin
            addr  = pick.addr;
            wcode = pick.wcode;
          end else if (roll < 12) begin
            addr = pick.addr;
          end
        end else if (roll < 70) begin
          addr  = pick.addr;
          wcode = pick.wcode;
        end else if (roll < 80) begin
          addr  = pick.addr;
          wcode = pick.wcode + WCODE_W'($urandom_range(1, 7));
        end
      end
      queue_access(is_write, addr, wcode, {$urandom, $urandom});
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_accesses.size() != 0 || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("register_write_shadow_store_unit verification clean");
    else
      $display("register_write_shadow_store_unit verification failed");
    $finish;
  end

endmodule
